// ----- sv/software_timer_table_defines.svh -----
// assertion macros for the software timer table
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define STT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STT_ASSERT(label, prop, msg)
`define STT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- sv/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and codes of the software timer table
// ----------------------------------------------------------------------------
package stt_pkg;
	localparam int TIME_W = 48;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [2:0] ACT_TICK     = 3'd0;
	localparam logic [2:0] ACT_SCHEDULE = 3'd1;
	localparam logic [2:0] ACT_CANCEL   = 3'd2;
	localparam logic [2:0] ACT_CLEAR    = 3'd3;
	localparam logic [2:0] ACT_RETIME   = 3'd4;

	localparam logic [2:0] RK_SCHEDULED = 3'd0;
	localparam logic [2:0] RK_FULL      = 3'd1;
	localparam logic [2:0] RK_FIRED     = 3'd2;
	localparam logic [2:0] RK_DONE      = 3'd3;
	localparam logic [2:0] RK_NOTFOUND  = 3'd4;
	localparam logic [2:0] RK_TICKEND   = 3'd5;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,      // capture input item, advance time on tick
		OP_SCAN,      // examine read index, fire / compact
		OP_SCHEDULE,
		OP_FIND,      // compare handle at read index
		OP_SHIFT,     // close up one entry
		OP_CANCEL_END,
		OP_CLEAR,
		OP_RETIME,
		OP_TICK_END
	} stt_op_t;

	typedef struct packed {
		stt_op_t op;
	} stt_cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       full;      // table holds all entries
		logic       scan_done; // read index reached count
		logic       fire;      // entry at read index is due
		logic       match;     // entry at read index has handle
		logic       shift_done;
	} stt_status_t;
endpackage

// ----- sv/stt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_datapath
// timer entry store, time counter, handle counter and scan indexes
// ----------------------------------------------------------------------------
module stt_datapath #(
	parameter int NUM_TIMERS  = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stt_pkg::stt_cmd_t       cmd,
	input  logic [2:0]              action,
	input  logic [31:0]             delay_amount,
	input  logic [31:0]             repeat_period,
	input  logic [15:0]             timer_handle,
	output stt_pkg::stt_status_t    status,
	output logic [15:0]             fire_handle
);
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int TW    = stt_pkg::TIME_W;

	logic [TW-1:0]          time_q;
	logic [HANDLE_BITS-1:0] next_handle_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       rd_q, wr_q;
	logic [2:0]             action_q;
	logic [31:0]            amount_q, period_in_q;
	logic [15:0]            key_q;

	logic [HANDLE_BITS-1:0] ent_handle [NUM_TIMERS];
	logic [TW-1:0]          ent_expiry [NUM_TIMERS];
	logic [31:0]            ent_period [NUM_TIMERS];

	logic [IDX_W-1:0]       rd_idx, rd_nx_idx, wr_idx, cnt_idx;
	logic [TW:0]            sum_dt, sum_amt, sum_per;
	logic [TW-1:0]          sat_amt, sat_per;
	logic [HANDLE_BITS-1:0] h_inc;

	assign rd_idx    = rd_q[IDX_W-1:0];
	assign wr_idx    = wr_q[IDX_W-1:0];
	assign cnt_idx   = count_q[IDX_W-1:0];
	assign rd_nx_idx = IDX_W'(rd_q + CNT_W'(1));

	assign sum_dt  = {1'b0, time_q} + (TW+1)'(delay_amount);
	assign sum_amt = {1'b0, time_q} + (TW+1)'(amount_q);
	assign sum_per = {1'b0, time_q} + (TW+1)'(ent_period[rd_idx]);
	assign sat_amt = sum_amt[TW] ? stt_pkg::TIME_MAX : sum_amt[TW-1:0];
	assign sat_per = sum_per[TW] ? stt_pkg::TIME_MAX : sum_per[TW-1:0];
	assign h_inc   = next_handle_q + HANDLE_BITS'(1);

	always_comb begin
		status.action     = action_q;
		status.full       = (count_q == CNT_W'(NUM_TIMERS));
		status.scan_done  = (rd_q >= count_q);
		status.fire       = (ent_expiry[rd_idx] < time_q);
		// both sides zero-extended, so a key above the handle range never matches
		status.match      = (32'(ent_handle[rd_idx]) == 32'(key_q));
		status.shift_done = (rd_q + CNT_W'(1) >= count_q);
	end

	assign fire_handle = (action_q == stt_pkg::ACT_SCHEDULE)
		? 16'(next_handle_q) : 16'(ent_handle[rd_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			next_handle_q <= HANDLE_BITS'(1);
			count_q       <= '0;
			rd_q          <= '0;
			wr_q          <= '0;
		end else begin
			case (cmd.op)
				stt_pkg::OP_LOAD: begin
					rd_q <= '0;
					wr_q <= '0;
					if (action == stt_pkg::ACT_TICK)
						time_q <= sum_dt[TW] ? stt_pkg::TIME_MAX : sum_dt[TW-1:0];
				end
				stt_pkg::OP_SCAN: begin
					rd_q <= rd_q + CNT_W'(1);
					if (!(status.fire && ent_period[rd_idx] == 32'd0))
						wr_q <= wr_q + CNT_W'(1);
				end
				stt_pkg::OP_TICK_END: count_q <= wr_q;
				stt_pkg::OP_SCHEDULE: begin
					count_q       <= count_q + CNT_W'(1);
					next_handle_q <= (h_inc == '0) ? HANDLE_BITS'(1) : h_inc;
				end
				stt_pkg::OP_FIND: if (!status.match) rd_q <= rd_q + CNT_W'(1);
				stt_pkg::OP_SHIFT: rd_q <= rd_q + CNT_W'(1);
				stt_pkg::OP_CANCEL_END: count_q <= count_q - CNT_W'(1);
				stt_pkg::OP_CLEAR: count_q <= '0;
				default: ;
			endcase
		end
	end

	// payload capture and entry store
	always_ff @(posedge clk) begin
		case (cmd.op)
			stt_pkg::OP_LOAD: begin
				action_q    <= action;
				amount_q    <= delay_amount;
				period_in_q <= repeat_period;
				key_q       <= timer_handle;
			end
			stt_pkg::OP_SCAN: begin
				if (!(status.fire && ent_period[rd_idx] == 32'd0)) begin
					ent_handle[wr_idx] <= ent_handle[rd_idx];
					ent_period[wr_idx] <= ent_period[rd_idx];
					ent_expiry[wr_idx] <= status.fire ? sat_per : ent_expiry[rd_idx];
				end
			end
			stt_pkg::OP_SCHEDULE: begin
				ent_handle[cnt_idx] <= next_handle_q;
				ent_expiry[cnt_idx] <= sat_amt;
				ent_period[cnt_idx] <= period_in_q;
			end
			stt_pkg::OP_SHIFT: begin
				ent_handle[rd_idx] <= ent_handle[rd_nx_idx];
				ent_expiry[rd_idx] <= ent_expiry[rd_nx_idx];
				ent_period[rd_idx] <= ent_period[rd_nx_idx];
			end
			stt_pkg::OP_RETIME: ent_expiry[rd_idx] <= sat_amt;
			default: ;
		endcase
	end
endmodule

// ----- sv/stt_control.sv -----
`timescale 1ns / 1ps
`include "software_timer_table_defines.svh"
// ----------------------------------------------------------------------------
// stt_control
// sequencer for one action and the result register
// ----------------------------------------------------------------------------
module stt_control (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           reply_kind,
	output logic [15:0]          reply_handle,
	output logic                 last_of_run,
	input  stt_pkg::stt_status_t status,
	input  logic [15:0]          fire_handle,
	output stt_pkg::stt_cmd_t    cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_SCAN, S_FIND, S_SHIFT, S_WAIT
	} state_t;

	state_t state_q;
	logic   busy_out;
	logic   emit;
	logic [2:0]  e_kind;
	logic [15:0] e_handle;
	logic        e_last;
	state_t      nxt;

	assign busy_out = out_valid && !out_ready;
	assign ready    = (state_q == S_IDLE);

	always_comb begin
		cmd.op   = stt_pkg::OP_NONE;
		emit     = 1'b0;
		e_kind   = stt_pkg::RK_DONE;
		e_handle = 16'd0;
		e_last   = 1'b1;
		nxt      = state_q;
		unique case (state_q)
			S_IDLE: if (valid) begin
				cmd.op = stt_pkg::OP_LOAD;
				nxt    = S_DISPATCH;
			end
			S_DISPATCH: if (!busy_out) begin
				emit = 1'b1;
				case (status.action) inside
					stt_pkg::ACT_TICK: begin
						emit = 1'b0;
						nxt  = S_SCAN;
					end
					stt_pkg::ACT_SCHEDULE: begin
						nxt = S_IDLE;
						if (status.full) e_kind = stt_pkg::RK_FULL;
						else begin
							cmd.op   = stt_pkg::OP_SCHEDULE;
							e_kind   = stt_pkg::RK_SCHEDULED;
							e_handle = fire_handle;
						end
					end
					stt_pkg::ACT_CANCEL, stt_pkg::ACT_RETIME: begin
						emit = 1'b0;
						nxt  = S_FIND;
					end
					stt_pkg::ACT_CLEAR: begin
						cmd.op = stt_pkg::OP_CLEAR;
						nxt    = S_IDLE;
					end
					default: nxt = S_IDLE;
				endcase
			end
			S_SCAN: if (!busy_out) begin
				if (status.scan_done) begin
					cmd.op = stt_pkg::OP_TICK_END;
					emit   = 1'b1;
					e_kind = stt_pkg::RK_TICKEND;
					nxt    = S_IDLE;
				end else begin
					cmd.op = stt_pkg::OP_SCAN;
					if (status.fire) begin
						emit     = 1'b1;
						e_kind   = stt_pkg::RK_FIRED;
						e_handle = fire_handle;
						e_last   = 1'b0;
					end
				end
			end
			S_FIND: if (!busy_out) begin
				if (status.scan_done) begin
					emit   = 1'b1;
					e_kind = stt_pkg::RK_NOTFOUND;
					nxt    = S_IDLE;
				end else if (status.match) begin
					cmd.op = stt_pkg::OP_FIND;
					if (status.action == stt_pkg::ACT_RETIME) begin
						cmd.op = stt_pkg::OP_RETIME;
						emit   = 1'b1;
						nxt    = S_IDLE;
					end else nxt = S_SHIFT;
				end else cmd.op = stt_pkg::OP_FIND;
			end
			S_SHIFT: if (!busy_out) begin
				if (status.shift_done) begin
					cmd.op = stt_pkg::OP_CANCEL_END;
					emit   = 1'b1;
					nxt    = S_IDLE;
				end else cmd.op = stt_pkg::OP_SHIFT;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid    <= 1'b0;
			reply_kind   <= stt_pkg::RK_DONE;
			reply_handle <= 16'd0;
			last_of_run  <= 1'b0;
		end else begin
			state_q <= nxt;
			if (emit) begin
				out_valid    <= 1'b1;
				reply_kind   <= e_kind;
				reply_handle <= e_handle;
				last_of_run  <= e_last;
			end else if (out_ready) out_valid <= 1'b0;
		end
	end

	`STT_ASSERT(a_ready_idle, ready |-> state_q == S_IDLE, "ready outside idle")
	`STT_ASSERT(a_no_overwrite, (out_valid && !out_ready) |=> $stable(reply_kind),
		"result overwritten while stalled")
	`STT_ASSERT(a_accept_dispatch, (valid && ready) |=> state_q == S_DISPATCH,
		"accepted item not dispatched")
	`STT_ASSERT(a_fired_not_last, (out_valid && reply_kind == stt_pkg::RK_FIRED)
		|-> !last_of_run, "fired result marked last")
endmodule

// ----- sv/software_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table
// table of one-shot and periodic timers, walked on each tick
// ----------------------------------------------------------------------------
// usage
//   input channel valid/ready carries action, delay_amount, repeat_period and
//   timer_handle; one transfer per action
//   output channel out_valid/out_ready carries reply_kind, reply_handle and
//   last_of_run; last_of_run marks the final result of an action
//   a tick gives one fired result per due entry, then a tick-end result
//   schedule, clear and unknown actions give their result from the dispatch
//   state; retime searches the entries up to the one at position i; cancel,
//   and any handle not found, walk every entry; a tick walks every entry
//   before its tick-end result; a new item is taken only after the last
//   one is done
//   the entry walk and the handle search share one read index, so one item
//   is worked on at a time
//   ready is high only while idle; a held result in the output register
//   stalls the sequencer until taken, nothing is dropped
//   reset empties the table, sets time to 0 and the next handle to 1
// ----------------------------------------------------------------------------
module software_timer_table #(
	parameter int NUM_TIMERS  = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [2:0]  action,
	input  logic [31:0] delay_amount,
	input  logic [31:0] repeat_period,
	input  logic [15:0] timer_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  reply_kind,
	output logic [15:0] reply_handle,
	output logic        last_of_run
);
	// command and status between sequencer and datapath
	stt_pkg::stt_cmd_t    cmd;
	stt_pkg::stt_status_t status;
	logic [15:0]          fire_handle;

	stt_datapath #(
		.NUM_TIMERS (NUM_TIMERS),
		.HANDLE_BITS(HANDLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.delay_amount (delay_amount),
		.repeat_period(repeat_period),
		.timer_handle (timer_handle),
		.status       (status),
		.fire_handle  (fire_handle)
	);

	stt_control u_control (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid       (valid),
		.ready       (ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.reply_kind  (reply_kind),
		.reply_handle(reply_handle),
		.last_of_run (last_of_run),
		.status      (status),
		.fire_handle (fire_handle),
		.cmd         (cmd)
	);
endmodule
